### rtl/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg
// shared constants and types of the ultrasonic range controller
// ----------------------------------------------------------------------------
`default_nettype none

package urc_pkg;

    // event codes
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_CAPTURE = 2'd1;
    localparam logic [1:0] CMD_WRAP    = 2'd2;

    // result codes
    localparam logic [1:0] KIND_TRIGGER   = 2'd0;
    localparam logic [1:0] KIND_DISTANCE  = 2'd1;
    localparam logic [1:0] KIND_RESET_REQ = 2'd2;

    // command word characters
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_M = 8'h6d;

    localparam logic [15:0] WRAP_MAX = 16'hffff;

    // register file
    localparam int unsigned PADDR_W = 3;
    localparam logic        REG_DEVICE_ADDRESS    = 1'b0;
    localparam logic        REG_MM_PER_TICK_SCALE = 1'b1;
    localparam logic [7:0]  DEVICE_ADDRESS_RESET    = 8'd97;
    // 340 m/s round trip at the timer clock, 24 fractional bits
    localparam logic [23:0] MM_PER_TICK_SCALE_RESET = 24'd178258;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [23:0] mm_per_tick_scale;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] ticks;
    } t_stage;

endpackage

`default_nettype wire

### rtl/urc_ifs.sv
// ----------------------------------------------------------------------------
// urc_ifs
// valid/ready channels for events in and results out
// ----------------------------------------------------------------------------
`default_nettype none

interface urc_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [15:0] capture_stamp;

    modport source(output valid, cmd, rx_byte, capture_stamp, input ready);
    modport sink(input valid, cmd, rx_byte, capture_stamp, output ready);
endinterface

interface urc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] echo_ticks;
    logic [31:0] distance_mm;

    modport source(output valid, result_kind, echo_ticks, distance_mm, input ready);
    modport sink(input valid, result_kind, echo_ticks, distance_mm, output ready);
endinterface

`default_nettype wire

### rtl/urc_cfg_regs.sv
// ----------------------------------------------------------------------------
// urc_cfg_regs
// apb register file: device address and distance scale
// ----------------------------------------------------------------------------
`default_nettype none

module urc_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [urc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output urc_pkg::t_cfg                    o_cfg
);

    logic          w_wr;
    logic          w_idx;
    urc_pkg::t_cfg r_cfg;
    urc_pkg::t_cfg n_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[urc_pkg::PADDR_W-1];

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                urc_pkg::REG_DEVICE_ADDRESS:    n_cfg.device_address    = pwdata[7:0];
                urc_pkg::REG_MM_PER_TICK_SCALE: n_cfg.mm_per_tick_scale = pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            urc_pkg::REG_DEVICE_ADDRESS:    prdata = {24'd0, r_cfg.device_address};
            urc_pkg::REG_MM_PER_TICK_SCALE: prdata = {8'd0, r_cfg.mm_per_tick_scale};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address    <= urc_pkg::DEVICE_ADDRESS_RESET;
            r_cfg.mm_per_tick_scale <= urc_pkg::MM_PER_TICK_SCALE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/urc_event_fsm.sv
// ----------------------------------------------------------------------------
// urc_event_fsm
// command decode, measurement phase, wrap count and tick stage register
// ----------------------------------------------------------------------------
`default_nettype none

module urc_event_fsm (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic        i_drain,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [15:0] i_capture_stamp,
    input  wire logic [7:0]  i_device_address,
    output urc_pkg::t_stage  o_stage
);

    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_WAIT_START = 2'd1;
    localparam logic [1:0] PH_WAIT_END   = 2'd2;

    logic [7:0]      r_hist [3];
    logic [7:0]      n_hist [3];
    logic [1:0]      r_phase;
    logic [1:0]      n_phase;
    logic [15:0]     r_start;
    logic [15:0]     n_start;
    logic [15:0]     r_wrap;
    logic [15:0]     n_wrap;
    urc_pkg::t_stage r_stage;
    urc_pkg::t_stage n_stage;

    logic        w_hit;
    logic [1:0]  w_kind;
    logic [31:0] w_ticks;
    logic [15:0] w_diff;
    logic        w_addr_ok;
    logic        w_rst_word;
    logic        w_dm_word;

    assign w_diff     = i_capture_stamp - r_start;
    assign w_addr_ok  = (i_rx_byte == i_device_address);
    assign w_rst_word = (r_hist[0] == urc_pkg::CH_R) && (r_hist[1] == urc_pkg::CH_S)
                        && (r_hist[2] == urc_pkg::CH_T);
    assign w_dm_word  = (r_hist[1] == urc_pkg::CH_D) && (r_hist[2] == urc_pkg::CH_M);

    always_comb begin
        n_hist  = r_hist;
        n_phase = r_phase;
        n_start = r_start;
        n_wrap  = r_wrap;
        w_hit   = 1'b0;
        w_kind  = urc_pkg::KIND_TRIGGER;
        w_ticks = '0;
        if (i_take) begin
            unique case (i_cmd)
                urc_pkg::CMD_BYTE: begin
                    // reset word wins over measure word
                    if (w_addr_ok && w_rst_word) begin
                        w_hit  = 1'b1;
                        w_kind = urc_pkg::KIND_RESET_REQ;
                    end else if (w_addr_ok && w_dm_word) begin
                        w_hit   = 1'b1;
                        w_kind  = urc_pkg::KIND_TRIGGER;
                        n_wrap  = '0;
                        n_phase = PH_WAIT_START;
                    end
                    n_hist[0] = r_hist[1];
                    n_hist[1] = r_hist[2];
                    n_hist[2] = i_rx_byte;
                end
                urc_pkg::CMD_CAPTURE: begin
                    if (r_phase == PH_WAIT_START) begin
                        n_start = i_capture_stamp;
                        n_phase = PH_WAIT_END;
                    end else if (r_phase == PH_WAIT_END) begin
                        // wraps weigh 2^16, difference taken modulo 2^16
                        w_hit   = 1'b1;
                        w_kind  = urc_pkg::KIND_DISTANCE;
                        w_ticks = {r_wrap, w_diff};
                        n_phase = PH_IDLE;
                    end
                end
                urc_pkg::CMD_WRAP: begin
                    if (r_phase == PH_WAIT_END && r_wrap != urc_pkg::WRAP_MAX) begin
                        n_wrap = r_wrap + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_stage = r_stage;
        if (i_take) begin
            n_stage.valid = w_hit;
            n_stage.kind  = w_kind;
            n_stage.ticks = w_ticks;
        end else if (i_drain) begin
            n_stage.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist[0] <= '0;
            r_hist[1] <= '0;
            r_hist[2] <= '0;
            r_phase   <= PH_IDLE;
            r_start   <= '0;
            r_wrap    <= '0;
            r_stage   <= '0;
        end else begin
            r_hist  <= n_hist;
            r_phase <= n_phase;
            r_start <= n_start;
            r_wrap  <= n_wrap;
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

`ifndef ASSERT_OFF
    a_trigger_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && w_hit && w_kind == urc_pkg::KIND_TRIGGER)
        |=> (r_phase == PH_WAIT_START && r_wrap == 16'd0 && r_stage.valid))
        else $error("measure word did not arm the capture");
    a_distance_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && w_hit && w_kind == urc_pkg::KIND_DISTANCE)
        |=> (r_phase == PH_IDLE && r_stage.valid))
        else $error("distance result did not return to idle");
    a_ticks_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage.valid && r_stage.kind != urc_pkg::KIND_DISTANCE)
        |-> (r_stage.ticks == 32'd0))
        else $error("non-distance result carries ticks");
`endif

endmodule

`default_nettype wire

### rtl/urc_dist_calc.sv
// ----------------------------------------------------------------------------
// urc_dist_calc
// ticks times scale into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module urc_dist_calc (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire urc_pkg::t_stage i_stage,
    input  wire logic [23:0]     i_scale,
    input  wire logic            i_ready,
    output logic                 o_drain,
    output logic                 o_valid,
    output logic [1:0]           o_kind,
    output logic [31:0]          o_ticks,
    output logic [31:0]          o_dist
);

    logic [55:0] w_prod;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [31:0] r_ticks;
    logic [31:0] r_dist;

    // 32 x 24 product, keep bits 55:24
    assign w_prod  = {24'd0, i_stage.ticks} * {32'd0, i_scale};
    assign o_drain = i_stage.valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_drain) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_drain) begin
            r_kind  <= i_stage.kind;
            r_ticks <= i_stage.ticks;
            r_dist  <= w_prod[55:24];
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_ticks = r_ticks;
    assign o_dist  = r_dist;

endmodule

`default_nettype wire

### rtl/ultrasonic_range_controller_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_controller_core
// event-driven ultrasonic time-of-flight ranging controller
// ----------------------------------------------------------------------------
// usage
//   i_evt carries one event per transfer: a serial byte, an echo capture
//   stamp or a timer period wrap. o_res carries a trigger request, a distance
//   result (ticks and mm) or a device reset request. most events give none.
//   the apb port holds the device address (0x0) and the mm-per-tick scale
//   (0x4); write it only while no event is in flight.
// pipeline and throughput
//   one event per cycle is taken while i_evt.ready is high. decode and state
//   update land in the stage register when the event transfers, and the 32 x
//   24 multiply goes into the output register when the stage drains; the result
//   then shows on o_res and transfers out while o_res.ready is high.
// reset
//   synchronous, active low: byte history cleared, phase idle, stamps and
//   wrap count zero, registers back to address 97 and the default scale.
// stall
//   a result waiting on o_res holds steady; one more result can wait in the
//   decode stage, and i_evt.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_controller_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    urc_evt_if.sink                          i_evt,
    urc_res_if.source                        o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [urc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    urc_pkg::t_cfg   w_cfg;
    urc_pkg::t_stage w_stage;
    logic            w_take;
    logic            w_drain;
    logic            w_ready;

    // decode stage frees up when empty or when it moves into the output register
    assign w_ready     = !w_stage.valid || w_drain;
    assign i_evt.ready = w_ready;
    assign w_take      = i_evt.valid && w_ready;

    urc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // command match, phase and wrap tracking, tick count
    urc_event_fsm u_fsm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (w_take),
        .i_drain          (w_drain),
        .i_cmd            (i_evt.cmd),
        .i_rx_byte        (i_evt.rx_byte),
        .i_capture_stamp  (i_evt.capture_stamp),
        .i_device_address (w_cfg.device_address),
        .o_stage          (w_stage)
    );

    // distance scaling and result register
    urc_dist_calc u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .i_scale (w_cfg.mm_per_tick_scale),
        .i_ready (o_res.ready),
        .o_drain (w_drain),
        .o_valid (o_res.valid),
        .o_kind  (o_res.result_kind),
        .o_ticks (o_res.echo_ticks),
        .o_dist  (o_res.distance_mm)
    );

endmodule

`default_nettype wire
